/* rtl/g2b_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the binarizer.
package g2b_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // Field and register widths
    localparam int PIX_W     = 8;
    localparam int BYTE_W    = 8;
    localparam int BYTE_SEL_W = 3;
    localparam int MODE_W    = 2;
    localparam int THR_W     = 9;
    localparam int DIM_W     = 11;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CUT_W     = 9;
    localparam int SUM_W     = 28;
    localparam int PROD_W    = 2 * DIM_W;

    // Error diffusion arithmetic
    localparam int Q_FRAC      = 8;
    localparam int ERR_W       = 20;
    localparam int DIFF_SHIFT  = 4;
    localparam int D_W         = ERR_W - DIFF_SHIFT;
    localparam int CARRY_W     = D_W + 3;
    localparam int DARK_LIMIT  = 32768;
    localparam int WHITE_Q8    = 65280;
    localparam int CUT_MAX     = 256;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd3;

    // Mode codes; the unused code behaves as fixed threshold
    localparam logic [MODE_W-1:0] MODE_DITHER = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MEAN   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FIXED  = 2'd2;

    // Reset values
    localparam logic [MODE_W-1:0] MODE_RST      = MODE_FIXED;
    localparam logic [THR_W-1:0]  THRESHOLD_RST = 9'd128;
    localparam logic [DIM_W-1:0]  WIDTH_RST     = 11'd1024;
    localparam logic [DIM_W-1:0]  HEIGHT_RST    = 11'd1024;
    localparam logic [CUT_W-1:0]  CUTOFF_RST    = 9'd128;

    typedef struct packed {
        logic capture;
        logic err_step;
        logic diff_step;
        logic update;
        logic mul_step;
        logic div_start;
        logic cutoff_load;
    } g2b_cmd_t;

    typedef struct packed {
        logic out_block;
        logic div_needed;
        logic div_done;
    } g2b_status_t;

endpackage

/* rtl/g2b_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module g2b_ram #(
    parameter int DATA_W = 20,
    parameter int DEPTH  = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/g2b_div.sv */
// Restoring divider, one quotient bit per cycle.
module g2b_div import g2b_pkg::*; #(
    parameter int NUM_W = SUM_W,
    parameter int DEN_W = PROD_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   trial;
    logic             fits;

    always_comb begin
        shifted = {rem_reg, quo_reg[NUM_W-1]};
        trial   = shifted - {1'b0, den};
        fits    = shifted >= {1'b0, den};

        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start) begin
            rem_next  = '0;
            quo_next  = num;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so the trial fits DEN_W bits
            rem_next = fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

/* rtl/g2b_datapath.sv */
// Datapath: config registers, position counters, error rows, bit packing, mean cutoff.
module g2b_datapath import g2b_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic [PIX_W-1:0]     in_pixel,
    input  logic                 in_measure,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [BYTE_W-1:0]    m_tdata,
    output logic                 m_tlast,
    output logic                 m_tuser,
    input  g2b_cmd_t             cmd,
    output g2b_status_t          status
);

    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT + 1);
    localparam int RAM_DEPTH = 2 * MAX_WIDTH;
    localparam int RAM_AW    = COL_W + 1;

    function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [ERR_W:0] v);
        logic signed [ERR_W-1:0] r;
        if (v[ERR_W] == v[ERR_W-1]) begin
            r = v[ERR_W-1:0];
        end else if (v[ERR_W]) begin
            r = {1'b1, {(ERR_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(ERR_W-1){1'b1}}};
        end
        return r;
    endfunction

    // Configuration
    logic [MODE_W-1:0] mode_reg;
    logic [THR_W-1:0]  thr_reg;
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [DIM_W-1:0]  w_used;
    logic [DIM_W-1:0]  h_used;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_RST;
            thr_reg    <= THRESHOLD_RST;
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_MODE:      mode_reg   <= cfg_wdata[MODE_W-1:0];
                REG_THRESHOLD: thr_reg    <= cfg_wdata[THR_W-1:0];
                REG_WIDTH:     width_reg  <= cfg_wdata[DIM_W-1:0];
                REG_HEIGHT:    height_reg <= cfg_wdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (width_reg == '0) begin
            w_used = DIM_W'(1);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            w_used = DIM_W'(MAX_WIDTH);
        end else begin
            w_used = width_reg;
        end
        if (height_reg == '0) begin
            h_used = DIM_W'(1);
        end else if (32'(height_reg) > MAX_HEIGHT) begin
            h_used = DIM_W'(MAX_HEIGHT);
        end else begin
            h_used = height_reg;
        end
    end

    // Captured item
    logic [PIX_W-1:0] pix_reg;
    logic             meas_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            pix_reg  <= in_pixel;
            meas_reg <= in_measure;
        end
    end

    // Position
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             last_col;
    logic             last_row;
    logic             byte_end;
    logic             dither;

    assign last_col = (32'(col_reg) + 1) >= 32'(w_used);
    assign last_row = (32'(row_reg) + 1) >= 32'(h_used);
    assign byte_end = (&col_reg[BYTE_SEL_W-1:0]) || last_col;
    assign dither   = (mode_reg == MODE_DITHER) && !meas_reg;

    // Error rows: one RAM, two banks. Reads come from the previous row's bank.
    logic                     bank_reg, bank_next;
    logic                     prev_valid_reg, prev_valid_next;
    logic [COL_W-1:0]         prev_last_reg;
    logic signed [ERR_W-1:0]  tail_reg;
    logic                     ram_we;
    logic [RAM_AW-1:0]        ram_waddr;
    logic [RAM_AW-1:0]        ram_raddr;
    logic [ERR_W-1:0]         ram_rdata;

    // Running next-row sums: na = next[x-1], nb = next[x] before item x
    logic signed [ERR_W-1:0]   na_reg, na_next, na_fin;
    logic signed [ERR_W-1:0]   nb_reg, nb_next, nb_new;
    logic signed [ERR_W-1:0]   nc_new;
    logic signed [CARRY_W-1:0] carry_reg, carry_next;

    assign ram_raddr = {~bank_reg, col_reg};
    assign ram_waddr = {bank_reg, col_reg - COL_W'(1)};
    assign ram_we    = cmd.update && (col_reg != '0);

    g2b_ram #(
        .DATA_W (ERR_W),
        .DEPTH  (RAM_DEPTH)
    ) u_err_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (na_fin),
        .re    (cmd.capture),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Stage 1: current error = stored row value plus the 7/16 share from the left
    logic signed [ERR_W-1:0] raw_err;
    logic signed [ERR_W-1:0] cur_err_reg;

    always_comb begin
        if (prev_valid_reg && (col_reg <= prev_last_reg)) begin
            raw_err = (col_reg == prev_last_reg) ? tail_reg : $signed(ram_rdata);
        end else begin
            raw_err = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.err_step) begin
            cur_err_reg <= sat_err((ERR_W+1)'(raw_err) + (ERR_W+1)'(carry_reg));
        end
    end

    // Stage 2: quantize in Q8 and scale the error by 1/16, truncating toward zero
    logic signed [ERR_W:0]   pix_q8;
    logic signed [ERR_W:0]   val;
    logic signed [ERR_W:0]   diff_w;
    logic signed [ERR_W-1:0] diff;
    logic signed [ERR_W-1:0] diff_adj;
    logic signed [ERR_W-1:0] diff_sh;
    logic                    dark_q;
    logic                    dark_q_reg;
    logic signed [D_W-1:0]   d_reg;

    always_comb begin
        pix_q8   = $signed({{(ERR_W+1-PIX_W-Q_FRAC){1'b0}}, pix_reg, {Q_FRAC{1'b0}}});
        val      = pix_q8 + (ERR_W+1)'(cur_err_reg);
        dark_q   = val < (ERR_W+1)'(DARK_LIMIT);
        diff_w   = dark_q ? val : val - (ERR_W+1)'(WHITE_Q8);
        diff     = diff_w[ERR_W-1:0];
        diff_adj = diff + (diff[ERR_W-1] ? ERR_W'((1 << DIFF_SHIFT) - 1) : ERR_W'(0));
        diff_sh  = diff_adj >>> DIFF_SHIFT;
    end

    always_ff @(posedge aclk) begin
        if (cmd.diff_step) begin
            d_reg      <= diff_sh[D_W-1:0];
            dark_q_reg <= dark_q;
        end
    end

    // Stage 3: spread 3/5/1 into the next row, 7 to the right
    logic signed [ERR_W:0] d_ext;
    logic signed [ERR_W:0] d3;
    logic signed [ERR_W:0] d5;
    logic signed [ERR_W:0] d7;

    always_comb begin
        d_ext = (ERR_W+1)'(d_reg);
        d3    = (d_ext <<< 1) + d_ext;
        d5    = (d_ext <<< 2) + d_ext;
        d7    = (d_ext <<< 3) - d_ext;
        if (dither) begin
            na_fin     = sat_err((ERR_W+1)'(na_reg) + d3);
            nb_new     = sat_err((ERR_W+1)'(nb_reg) + d5);
            nc_new     = last_col ? ERR_W'(0) : ERR_W'(d_reg);
            carry_next = last_col ? CARRY_W'(0) : d7[CARRY_W-1:0];
        end else begin
            na_fin     = na_reg;
            nb_new     = nb_reg;
            nc_new     = '0;
            carry_next = '0;
        end
    end

    // Classification and packing
    logic [CUT_W-1:0]  cutoff_reg;
    logic              dark_bit;
    logic [BYTE_W-1:0] acc_reg, acc_next;
    logic [BYTE_W-1:0] acc_or;
    logic              emit;

    always_comb begin
        case (mode_reg)
            MODE_DITHER: dark_bit = dark_q_reg;
            MODE_MEAN:   dark_bit = {1'b0, pix_reg} < cutoff_reg;
            default:     dark_bit = {1'b0, pix_reg} < thr_reg;
        endcase
        acc_or = acc_reg | (BYTE_W'(dark_bit) << col_reg[BYTE_SEL_W-1:0]);
        emit   = !meas_reg && byte_end;
        if (meas_reg || emit) begin
            acc_next = '0;
        end else begin
            acc_next = acc_or;
        end
    end

    // Frame sum for the mean cutoff
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [SUM_W:0]   sum_wide;
    logic [SUM_W-1:0] sum_sat;
    logic [SUM_W-1:0] div_num_reg;
    logic [PROD_W-1:0] prod_reg;
    logic             div_done;
    logic [SUM_W-1:0] div_quo;
    logic             frame_done;

    assign sum_wide   = {1'b0, sum_reg} + (SUM_W+1)'(pix_reg);
    assign sum_sat    = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
    assign frame_done = last_col && last_row;

    always_comb begin
        sum_next = sum_reg;
        if (meas_reg) begin
            sum_next = frame_done ? SUM_W'(0) : sum_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update && meas_reg && frame_done) begin
            div_num_reg <= sum_sat;
        end
        if (cmd.mul_step) begin
            prod_reg <= PROD_W'(w_used) * PROD_W'(h_used);
        end
    end

    g2b_div #(
        .NUM_W (SUM_W),
        .DEN_W (PROD_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num_reg),
        .den     (prod_reg),
        .done    (div_done),
        .quo     (div_quo)
    );

    // Position and row bookkeeping
    always_comb begin
        col_next        = col_reg;
        row_next        = row_reg;
        bank_next       = bank_reg;
        prev_valid_next = prev_valid_reg;
        na_next         = na_reg;
        nb_next         = nb_reg;
        if (last_col) begin
            col_next        = '0;
            row_next        = last_row ? ROW_W'(0) : row_reg + ROW_W'(1);
            bank_next       = ~bank_reg;
            prev_valid_next = !last_row;
            na_next         = '0;
            nb_next         = '0;
        end else begin
            col_next = col_reg + COL_W'(1);
            na_next  = nb_new;
            nb_next  = nc_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update && last_col) begin
            tail_reg      <= nb_new;
            prev_last_reg <= col_reg;
        end
    end

    // Output register
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_bits_reg;
    logic              out_row_end_reg;
    logic              out_frame_end_reg;
    logic              out_load;

    assign out_load = cmd.update && emit;

    always_comb begin
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_bits_reg      <= acc_or;
            out_row_end_reg   <= last_col;
            out_frame_end_reg <= frame_done;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg        <= '0;
            row_reg        <= '0;
            acc_reg        <= '0;
            sum_reg        <= '0;
            cutoff_reg     <= CUTOFF_RST;
            bank_reg       <= 1'b0;
            prev_valid_reg <= 1'b0;
            na_reg         <= '0;
            nb_reg         <= '0;
            carry_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (cmd.update) begin
                col_reg        <= col_next;
                row_reg        <= row_next;
                acc_reg        <= acc_next;
                sum_reg        <= sum_next;
                bank_reg       <= bank_next;
                prev_valid_reg <= prev_valid_next;
                na_reg         <= na_next;
                nb_reg         <= nb_next;
                carry_reg      <= last_col ? CARRY_W'(0) : carry_next;
            end
            if (cmd.cutoff_load) begin
                cutoff_reg <= (div_quo > SUM_W'(CUT_MAX)) ? CUT_W'(CUT_MAX)
                                                          : div_quo[CUT_W-1:0];
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_bits_reg;
    assign m_tlast  = out_row_end_reg;
    assign m_tuser  = out_frame_end_reg;

    assign status.out_block  = emit && out_valid_reg && !m_tready;
    assign status.div_needed = meas_reg && frame_done;
    assign status.div_done   = div_done;

endmodule

/* rtl/g2b_ctrl.sv */
// Controller: sequences each item through the datapath stages and the cutoff division.
module g2b_ctrl import g2b_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  g2b_status_t status,
    output g2b_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ERR  = 3'd1;
    localparam logic [2:0] ST_DIFF = 3'd2;
    localparam logic [2:0] ST_UPD  = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_DST  = 3'd5;
    localparam logic [2:0] ST_DIV  = 3'd6;

    logic [2:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_ERR;
                end
            end
            ST_ERR: begin
                cmd.err_step = 1'b1;
                state_next   = ST_DIFF;
            end
            ST_DIFF: begin
                cmd.diff_step = 1'b1;
                state_next    = ST_UPD;
            end
            ST_UPD: begin
                // hold while the previous byte still sits in the output register
                if (!status.out_block) begin
                    cmd.update = 1'b1;
                    state_next = status.div_needed ? ST_MUL : ST_IDLE;
                end
            end
            ST_MUL: begin
                cmd.mul_step = 1'b1;
                state_next   = ST_DST;
            end
            ST_DST: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                if (status.div_done) begin
                    cmd.cutoff_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/gray_to_bitmap_binarizer.sv */
// Gray to packed bitmap binarizer: fixed threshold, frame mean threshold or error diffusion.
// A byte is shown on m_tvalid once the item that completes it has passed error add, quantize
// and update into the output register, later while the previous byte still waits there.
// Pixels are taken one at a time: accept and error read, error add, quantize, update.
// The last pixel of a measuring frame also runs the product and the 28-step cutoff division.
// Reset (aresetn low, synchronous) restores register defaults and clears counters, sums and
// error history; error RAM needs no clearing pass.
module gray_to_bitmap_binarizer import g2b_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [PIX_W-1:0]     s_tdata,   // [7:0] pixel
    input  logic                 s_tuser,   // [0] measure_pass
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [BYTE_W-1:0]    m_tdata,   // [7:0] packed_bits
    output logic                 m_tlast,   // row_end
    output logic                 m_tuser    // [0] frame_end
);

    g2b_cmd_t    cmd;
    g2b_status_t status;

    g2b_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    g2b_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_pixel   (s_tdata),
        .in_measure (s_tuser),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .cmd        (cmd),
        .status     (status)
    );

endmodule

/* rtl/g2b_checker.sv */
// Port-level checks for the binarizer, bound to the top level.
module g2b_checker import g2b_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [BYTE_W-1:0] m_tdata,
    input logic              m_tlast,
    input logic              m_tuser
);

    // a stalled byte holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("output item changed while stalled");

    // the byte that closes a frame also closes a row
    a_frame_in_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame end without row end");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // one item at a time: no back-to-back acceptance
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted in consecutive cycles");

    // a result never appears the cycle right after an acceptance
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result shown too early");

endmodule

bind gray_to_bitmap_binarizer g2b_checker u_g2b_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for gray_to_bitmap_binarizer: directed table, then random frames.
module tb_top;
    import g2b_pkg::*;

    localparam int MAX_W           = MAX_WIDTH_DEF;
    localparam int MAX_H           = MAX_HEIGHT_DEF;
    localparam int RANDOM_ITEMS    = 750;
    localparam int CALM_TAIL       = 120;   // final items sent with no idling
    localparam int SETTLE_CYCLES   = 64;    // output latency plus the cutoff division
    localparam int PRESSURE_AT     = 300;
    localparam int PRESSURE_CYCLES = 400;
    localparam int SMALL_FRAME     = 160;
    localparam int ERR_HI          = (1 << (ERR_W - 1)) - 1;
    localparam int ERR_LO          = -(1 << (ERR_W - 1));

    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] bits;
        logic              row_end;
        logic              frame_end;
    } bitmap_byte_t;

    typedef enum logic {ROW_CFG, ROW_PIX} row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     val;
        logic [PIX_W-1:0]     pix;
        logic                 meas;
        logic                 typed;
        bitmap_byte_t         want;
    } stim_row_t;

    localparam bitmap_byte_t NO_BYTE = '{8'h00, 1'b0, 1'b0};
    localparam int DIR_ROWS = 43;

    localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
        '{ROW_CFG, REG_WIDTH,     11'd3,    8'd0,   1'b0, 1'b0, NO_BYTE},
        '{ROW_CFG, REG_HEIGHT,    11'd2,    8'd0,   1'b0, 1'b0, NO_BYTE},
        '{ROW_PIX, REG_MODE,      11'd0,    8'd0,   1'b0, 1'b0, NO_BYTE},
        '{ROW_PIX, REG_MODE,      11'd0,    8'd255, 1'b0, 1'b0, NO_BYTE},
        '{ROW_PIX, REG_MODE,      11'd0,    8'd127, 1'b0, 1'b1, '{8'h05, 1'b1, 1'b0}},
        '{ROW_PIX, REG_MODE,      11'd0,    8'd128, 1'b0, 1'b0, NO_BYTE},
        '{ROW_PIX, REG_MODE,      11'd0,    8'd1,   1'b0, 1'b0, NO_BYTE},
        '{ROW_PIX, REG_MODE,      11'd0,    8'd254, 1'b0, 1'b1, '{8'h02, 1'b1, 1'b1}},
        // cutoff extremes on a 1x1 frame (zero sizes clamp to one)
        '{ROW_CFG, REG_THRESHOLD, 11'd256,  8'd0,   1'b0, 1'b0, NO_BYTE},
        '{ROW_CFG, REG_WIDTH,     11'd0,    8'd0,   1'b0, 1'b0, NO_BYTE},
        '{ROW_CFG, REG_HEIGHT,    11'd0,    8'd0,   1'b0, 1'b0, NO_BYTE},
        '{ROW_PIX, REG_MODE,      11'd0,    8'd255, 1'b0, 1'b1, '{8'h01, 1'b1, 1'b1}},
        '{ROW_CFG, REG_THRESHOLD, 11'd0,    8'd0,   1'b0, 1'b0, NO_BYTE},
        '{ROW_PIX, REG_MODE,      11'd0,    8'd0,   1'b0, 1'b1, '{8'h00, 1'b1, 1'b1}},
        // unused mode code acts as fixed cutoff
        '{ROW_CFG, REG_MODE,      11'(MODE_SPARE), 8'd0, 1'b0, 1'b0, NO_BYTE},
        '{ROW_CFG, REG_THRESHOLD, 11'd1,    8'd0,   1'b0, 1'b0, NO_BYTE},
        '{ROW_PIX, REG_MODE,      11'd0,    8'd0,   1'b0, 1'b1, '{8'h01, 1'b1, 1'b1}},
        // oversize width clamps to the max; one full byte mid-row
        '{ROW_CFG, REG_WIDTH,     11'd2047, 8'd0,   1'b0, 1'b0, NO_BYTE},
        '{ROW_CFG, REG_HEIGHT,    11'd1,    8'd0,   1'b0, 1'b0, NO_BYTE},
        '{ROW_PIX, REG_MODE,      11'd0,    8'd0,   1'b0, 1'b0, NO_BYTE},
        '{ROW_PIX, REG_MODE,      11'd0,    8'd255, 1'b0, 1'b0, NO_BYTE},
        '{ROW_PIX, REG_MODE,      11'd0,    8'd0,   1'b0, 1'b0, NO_BYTE},
        '{ROW_PIX, REG_MODE,      11'd0,    8'd255, 1'b0, 1'b0, NO_BYTE},
        '{ROW_PIX, REG_MODE,      11'd0,    8'd0,   1'b0, 1'b0, NO_BYTE},
        '{ROW_PIX, REG_MODE,      11'd0,    8'd255, 1'b0, 1'b0, NO_BYTE},
        '{ROW_PIX, REG_MODE,      11'd0,    8'd0,   1'b0, 1'b0, NO_BYTE},
        '{ROW_PIX, REG_MODE,      11'd0,    8'd0,   1'b0, 1'b1, '{8'hD5, 1'b0, 1'b0}},
        // width shrunk below the column in progress: next pixel closes row and frame
        '{ROW_CFG, REG_WIDTH,     11'd4,    8'd0,   1'b0, 1'b0, NO_BYTE},
        '{ROW_PIX, REG_MODE,      11'd0,    8'd0,   1'b0, 1'b1, '{8'h01, 1'b1, 1'b1}},
        '{ROW_CFG, REG_MODE,      11'(MODE_DITHER), 8'd0, 1'b0, 1'b0, NO_BYTE},
        '{ROW_CFG, REG_WIDTH,     11'd2,    8'd0,   1'b0, 1'b0, NO_BYTE},
        '{ROW_CFG, REG_HEIGHT,    11'd2,    8'd0,   1'b0, 1'b0, NO_BYTE},
        '{ROW_PIX, REG_MODE,      11'd0,    8'd255, 1'b0, 1'b0, NO_BYTE},
        '{ROW_PIX, REG_MODE,      11'd0,    8'd0,   1'b0, 1'b0, NO_BYTE},
        '{ROW_PIX, REG_MODE,      11'd0,    8'd128, 1'b0, 1'b0, NO_BYTE},
        '{ROW_PIX, REG_MODE,      11'd0,    8'd127, 1'b0, 1'b0, NO_BYTE},
        // measure 10 and 31 -> cutoff 20
        '{ROW_CFG, REG_MODE,      11'(MODE_MEAN), 8'd0, 1'b0, 1'b0, NO_BYTE},
        '{ROW_CFG, REG_WIDTH,     11'd2,    8'd0,   1'b0, 1'b0, NO_BYTE},
        '{ROW_CFG, REG_HEIGHT,    11'd1,    8'd0,   1'b0, 1'b0, NO_BYTE},
        '{ROW_PIX, REG_MODE,      11'd0,    8'd10,  1'b1, 1'b0, NO_BYTE},
        '{ROW_PIX, REG_MODE,      11'd0,    8'd31,  1'b1, 1'b0, NO_BYTE},
        '{ROW_PIX, REG_MODE,      11'd0,    8'd19,  1'b0, 1'b0, NO_BYTE},
        '{ROW_PIX, REG_MODE,      11'd0,    8'd20,  1'b0, 1'b1, '{8'h01, 1'b1, 1'b1}}
    };

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [PIX_W-1:0]     s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [BYTE_W-1:0]    m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;

    // register mirror and block state as seen by the predictor
    logic [MODE_W-1:0]      cur_mode;
    logic [THR_W-1:0]       cur_thr;
    logic [DIM_W-1:0]       cur_width;
    logic [DIM_W-1:0]       cur_height;
    logic [9:0]             col_cnt;
    logic [9:0]             row_cnt;
    logic [BYTE_W-1:0]      bit_acc;
    logic signed [ERR_W-1:0] err_cur [MAX_W + 2];
    logic signed [ERR_W-1:0] err_nxt [MAX_W + 2];
    logic [SUM_W-1:0]       pix_sum;
    logic [CUT_W-1:0]       cutoff;

    bitmap_byte_t pending_bytes [$];
    int  pixels_sent = 0;
    int  mismatch_cnt = 0;
    bit  idling = 1'b1;
    bit  pressure_done = 1'b0;

    gray_to_bitmap_binarizer DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("** gray_to_bitmap_binarizer: FAILED **");
        $finish;
    end

    function automatic int used_dim(input logic [DIM_W-1:0] v, input int lim);
        if (v == 0) return 1;
        if (int'(v) > lim) return lim;
        return int'(v);
    endfunction

    function automatic logic signed [ERR_W-1:0] clip_err(input int v);
        if (v > ERR_HI) return ERR_W'(ERR_HI);
        if (v < ERR_LO) return ERR_W'(ERR_LO);
        return ERR_W'(v);
    endfunction

    function automatic void clear_err_rows();
        for (int i = 0; i < MAX_W + 2; i++) begin
            err_cur[i] = '0;
            err_nxt[i] = '0;
        end
    endfunction

    function automatic void reset_binarizer_model();
        cur_mode   = MODE_RST;
        cur_thr    = THRESHOLD_RST;
        cur_width  = WIDTH_RST;
        cur_height = HEIGHT_RST;
        col_cnt    = '0;
        row_cnt    = '0;
        bit_acc    = '0;
        pix_sum    = '0;
        cutoff     = CUTOFF_RST;
        clear_err_rows();
    endfunction

    // Q8 error diffusion at column x; returns the dark bit
    function automatic logic diffuse_at(input int x, input int w, input logic [PIX_W-1:0] pix);
        int   val;
        int   delta;
        logic dark;
        val = int'(pix) * 256 + int'(err_cur[x]);
        if (val < DARK_LIMIT) begin
            dark  = 1'b1;
            delta = val;
        end else begin
            dark  = 1'b0;
            delta = val - WHITE_Q8;
        end
        delta = delta / 16;
        if (x + 1 < w) begin
            err_cur[x + 1] = clip_err(int'(err_cur[x + 1]) + 7 * delta);
            err_nxt[x + 1] = clip_err(int'(err_nxt[x + 1]) + delta);
        end
        if (x > 0)
            err_nxt[x - 1] = clip_err(int'(err_nxt[x - 1]) + 3 * delta);
        err_nxt[x] = clip_err(int'(err_nxt[x]) + 5 * delta);
        err_cur[x] = '0;
        return dark;
    endfunction

    // advances the state by one pixel; returns 1 when a byte comes out
    function automatic bit binarize_pixel(input logic [PIX_W-1:0] pix, input logic meas,
                                          output bitmap_byte_t res);
        int           w;
        int           h;
        int           x;
        int           q;
        logic         last_col;
        logic         last_row;
        logic         dark;
        logic [SUM_W:0] s;
        bit           has;
        w = used_dim(cur_width, MAX_W);
        h = used_dim(cur_height, MAX_H);
        x = int'(col_cnt);
        last_col = (x + 1 >= w);
        last_row = (int'(row_cnt) + 1 >= h);
        if (x >= MAX_W) x = MAX_W - 1;
        has = 1'b0;
        res = NO_BYTE;
        if (meas) begin
            s = {1'b0, pix_sum} + pix;
            pix_sum = s[SUM_W] ? '1 : s[SUM_W-1:0];
            bit_acc = '0;
        end else begin
            if (cur_mode == MODE_DITHER)
                dark = diffuse_at(x, w, pix);
            else if (cur_mode == MODE_MEAN)
                dark = (pix < cutoff);
            else
                dark = (pix < cur_thr);
            bit_acc = bit_acc | (BYTE_W'(dark) << x[2:0]);
            if (x[2:0] == 3'd7 || last_col) begin
                res.bits      = bit_acc;
                res.row_end   = last_col;
                res.frame_end = last_col & last_row;
                bit_acc = '0;
                has = 1'b1;
            end
        end
        if (last_col) begin
            col_cnt = '0;
            for (int i = 0; i < MAX_W + 2; i++) begin
                err_cur[i] = err_nxt[i];
                err_nxt[i] = '0;
            end
            if (last_row) begin
                row_cnt = '0;
                if (meas) begin
                    q = int'(pix_sum) / (w * h);
                    cutoff = (q > CUT_MAX) ? CUT_W'(CUT_MAX) : CUT_W'(q);
                    pix_sum = '0;
                end
                clear_err_rows();
            end else begin
                row_cnt = row_cnt + 1'b1;
            end
        end else begin
            col_cnt = 10'(x + 1);
        end
        return has;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MODE:      cur_mode   = val[MODE_W-1:0];
            REG_THRESHOLD: cur_thr    = val[THR_W-1:0];
            REG_WIDTH:     cur_width  = val[DIM_W-1:0];
            REG_HEIGHT:    cur_height = val[DIM_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // wait until every byte is out, then let a cutoff division finish
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic meas,
                              input logic typed, input bitmap_byte_t want);
        bitmap_byte_t res;
        bit           has;
        if (idling && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= meas;
        do @(posedge aclk); while (!s_tready);
        has = binarize_pixel(pix, meas, res);
        if (typed)
            pending_bytes.push_back(want);
        else if (has)
            pending_bytes.push_back(res);
        pixels_sent++;
    endtask

    function automatic logic [PIX_W-1:0] rand_pixel(input int lo, input int hi);
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return PIX_W'($urandom_range(lo, hi));
        endcase
    endfunction

    task automatic send_frame(input int n, input logic meas);
        int lo;
        int hi;
        lo = $urandom_range(0, 255);
        hi = $urandom_range(lo, 255);
        repeat (n) send_pixel(rand_pixel(lo, hi), meas, 1'b0, NO_BYTE);
    endtask

    task automatic run_phase();
        int                pick;
        int                area;
        logic [MODE_W-1:0] md;
        logic [THR_W-1:0]  thr;
        logic [DIM_W-1:0]  w_val;
        logic [DIM_W-1:0]  h_val;
        settle();
        pick = $urandom_range(0, 9);
        md = (pick < 4) ? MODE_DITHER : (pick < 7) ? MODE_MEAN :
             (pick < 9) ? MODE_FIXED : MODE_SPARE;
        // upper data bits beyond a register are don't-care
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_MODE, {9'($urandom), md});
        else
            write_reg(REG_MODE, CFG_W'(md));
        if (md != MODE_DITHER && md != MODE_MEAN || $urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 5))
                0:       thr = 9'd0;
                1:       thr = 9'd256;
                default: thr = THR_W'($urandom_range(0, 256));
            endcase
            write_reg(REG_THRESHOLD, {2'($urandom), thr});
        end
        if ($urandom_range(0, 15) == 0) begin
            case ($urandom_range(0, 4))
                0:       w_val = 11'd0;
                1:       w_val = 11'd1023;
                2:       w_val = 11'd1024;
                3:       w_val = 11'd2047;
                default: w_val = DIM_W'($urandom_range(25, 1024));
            endcase
        end else begin
            w_val = DIM_W'($urandom_range(1, 24));
        end
        if ($urandom_range(0, 15) == 0) begin
            case ($urandom_range(0, 2))
                0:       h_val = 11'd0;
                1:       h_val = 11'd1024;
                default: h_val = 11'd2047;
            endcase
        end else begin
            h_val = DIM_W'($urandom_range(1, 6));
        end
        write_reg(REG_WIDTH, w_val);
        write_reg(REG_HEIGHT, h_val);
        area = used_dim(w_val, MAX_W) * used_dim(h_val, MAX_H);

        if ($urandom_range(0, 4) == 0) begin
            // noise: random length, measuring flag at random
            repeat ($urandom_range(1, 40))
                send_pixel(rand_pixel(0, 255), 1'($urandom), 1'b0, NO_BYTE);
        end else if (area > SMALL_FRAME) begin
            send_frame($urandom_range(1, 48), 1'b0);
        end else begin
            // close any frame left open so the next ones start aligned
            while (col_cnt != 0 || row_cnt != 0)
                send_pixel(rand_pixel(0, 255), 1'b0, 1'b0, NO_BYTE);
            if (md == MODE_MEAN || $urandom_range(0, 7) == 0)
                send_frame(area, 1'b1);
            send_frame(area, 1'b0);
            if ($urandom_range(0, 2) == 0)
                send_frame(area, 1'b0);
        end
    endtask

    // receiver: short random stalls, plus one long hold-off to back up the input
    initial begin
        int stall;
        int hold;
        stall = 0;
        hold  = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (!pressure_done && pixels_sent >= PRESSURE_AT) begin
                pressure_done = 1'b1;
                hold = PRESSURE_CYCLES;
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else if (idling && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 3) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : check_bytes
        bitmap_byte_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_bytes.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("%0t: unexpected byte bits=%02h row_end=%0b frame_end=%0b",
                             $realtime, m_tdata, m_tlast, m_tuser);
            end else begin
                want = pending_bytes.pop_front();
                if (m_tdata !== want.bits || m_tlast !== want.row_end ||
                    m_tuser !== want.frame_end) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: byte mismatch exp bits=%02h row_end=%0b frame_end=%0b %s",
                                 $realtime, want.bits, want.row_end, want.frame_end,
                                 $sformatf("got bits=%02h row_end=%0b frame_end=%0b",
                                           m_tdata, m_tlast, m_tuser));
                end
            end
        end
    end

    initial begin
        bit prev_cfg;
        int rand_end;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_MODE;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        reset_binarizer_model();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        prev_cfg = 1'b1;
        for (int k = 0; k < DIR_ROWS; k++) begin
            if (DIR_TAB[k].kind == ROW_CFG) begin
                if (!prev_cfg) settle();
                write_reg(DIR_TAB[k].idx, DIR_TAB[k].val);
                prev_cfg = 1'b1;
            end else begin
                send_pixel(DIR_TAB[k].pix, DIR_TAB[k].meas, DIR_TAB[k].typed,
                           DIR_TAB[k].want);
                prev_cfg = 1'b0;
            end
        end

        rand_end = pixels_sent + RANDOM_ITEMS;
        while (pixels_sent < rand_end) begin
            if (pixels_sent >= rand_end - CALM_TAIL) idling = 1'b0;
            run_phase();
        end

        settle();
        if (mismatch_cnt == 0 && pending_bytes.size() == 0)
            $display("** gray_to_bitmap_binarizer: PASSED **");
        else
            $display("** gray_to_bitmap_binarizer: FAILED **");
        $finish;
    end

endmodule
